// ===== design/mrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrt_pkg
// shared item types, record codes and parser phases for the table dump parser
// ----------------------------------------------------------------------------
package mrt_pkg;

   localparam int OFFSET_BITS = 32;

   localparam logic [15:0] TYPE_TD2       = 16'd13;
   localparam logic [15:0] SUB_PEER_TABLE = 16'd1;
   localparam logic [15:0] SUB_RIB_V4U    = 16'd2;
   localparam logic [15:0] SUB_LAST_KNOWN = 16'd6;

   localparam logic [1:0] KIND_PEER_V4 = 2'd0;
   localparam logic [1:0] KIND_PEER_V6 = 2'd1;
   localparam logic [1:0] KIND_RIB     = 2'd2;
   localparam logic [1:0] KIND_DONE    = 2'd3;

   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_TYPE     = 3'd1;
   localparam logic [2:0] ERR_SUBTYPE  = 3'd2;
   localparam logic [2:0] ERR_LENGTH   = 3'd3;
   localparam logic [2:0] ERR_PEER_IDX = 3'd4;
   localparam logic [2:0] ERR_EARLY    = 3'd5;

   localparam logic [4:0] PH_HDR      = 5'd0;
   localparam logic [4:0] PH_SKIP     = 5'd1;
   localparam logic [4:0] PH_DRAIN    = 5'd2;
   localparam logic [4:0] PH_PT_COLL  = 5'd3;
   localparam logic [4:0] PH_PT_VNLEN = 5'd4;
   localparam logic [4:0] PH_PT_VNAME = 5'd5;
   localparam logic [4:0] PH_PT_COUNT = 5'd6;
   localparam logic [4:0] PH_PT_TYPE  = 5'd7;
   localparam logic [4:0] PH_PT_BGPID = 5'd8;
   localparam logic [4:0] PH_PT_ADDR  = 5'd9;
   localparam logic [4:0] PH_PT_AS    = 5'd10;
   localparam logic [4:0] PH_PT_TRAIL = 5'd11;
   localparam logic [4:0] PH_RIB_SEQ  = 5'd12;
   localparam logic [4:0] PH_RIB_PLEN = 5'd13;
   localparam logic [4:0] PH_RIB_PFX  = 5'd14;
   localparam logic [4:0] PH_RIB_COUNT = 5'd15;
   localparam logic [4:0] PH_RIB_PEER = 5'd16;
   localparam logic [4:0] PH_RIB_TIME = 5'd17;
   localparam logic [4:0] PH_RIB_ALEN = 5'd18;
   localparam logic [4:0] PH_RIB_ATTR = 5'd19;
   localparam logic [4:0] PH_RIB_END  = 5'd20;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        last_of_run;
      logic [15:0] peer_slot;
      logic [31:0] peer_as;
      logic [31:0] bgp_id;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [5:0]  pfx_len;
      logic [15:0] attr_len;
      logic [31:0] attribute_offset;
      logic [15:0] record_subtype;
      logic [2:0]  error_code;
   } rsp_type;

   // parser step outcome handed to the output stage
   typedef struct packed {
      logic    count0;
      logic    count1;
      rsp_type res0;
      rsp_type res1;
   } step_type;

endpackage

// ===== design/mrt_out_queue.sv =====
// ----------------------------------------------------------------------------
// mrt_out_queue
// two-entry result buffer that takes up to two items at once
// ----------------------------------------------------------------------------
module mrt_out_queue
   import mrt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  step_type push_step,
   output logic     has_room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   rsp_type    slot_ff [2];
   rsp_type    slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] n_push;
   logic [1:0] left;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   // room only when the queue is empty, or will be after this pop
   assign has_room  = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);
   assign n_push    = push_valid ? ({1'b0, push_step.count0} + {1'b0, push_step.count1})
                                 : 2'd0;

   // shift out popped item, append new ones
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      left = cnt_ff - {1'b0, pop};
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (n_push != 2'd0) begin
         if (left == 2'd0) begin
            slot_in[0] = push_step.res0;
            slot_in[1] = push_step.res1;
         end else begin
            slot_in[1] = push_step.res0;
         end
      end
      cnt_in = left + n_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

// ===== design/mrt_table_dump_stream_parser.sv =====
// ----------------------------------------------------------------------------
// mrt_table_dump_stream_parser
// byte-wide parser for table dump records: peers, rib entries, record done
// ----------------------------------------------------------------------------
// channel | direction | payload  | handshake
// req_    | in        | req_type | req_valid / req_ready
// rsp_    | out       | rsp_type | rsp_valid / rsp_ready
//
// one byte is parsed per clock while req_ready is high; a byte's up to two
// items land in the output queue as the byte is taken, and items leave one
// per cycle while rsp_ready is high. req_ready is high whenever the queue is
// empty or drains this cycle, so a byte giving two items holds off the next byte.
// reset is synchronous and returns the parser to the start of a header.
module mrt_table_dump_stream_parser
   import mrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [4:0]  phase_ff, phase_in;
   logic [4:0]  fcnt_ff, fcnt_in;
   logic [63:0] facc_ff, facc_in;
   logic [63:0] aacc_ff, aacc_in;
   logic [63:0] alow_ff, alow_in;
   logic [31:0] rlen_ff, rlen_in;
   logic [31:0] left_ff, left_in;
   logic [15:0] sub_ff, sub_in;
   logic [15:0] ptot_ff, ptot_in;
   logic [15:0] items_ff, items_in;
   logic [15:0] skip_ff, skip_in;
   logic [1:0]  ptype_ff, ptype_in;
   logic [31:0] pfx_ff, pfx_in;
   logic [5:0]  plen_ff, plen_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [15:0] pnum_ff, pnum_in;

   step_type    step;
   logic        take_ok;
   logic        accept;
   logic        nres;
   logic [7:0]  b;
   logic [63:0] tk_acc;
   logic [4:0]  tk_cnt;
   logic [31:0] hdr_acc;
   logic [15:0] typ;
   logic [31:0] bleft;
   logic        open;
   logic [5:0]  nbytes;
   logic [15:0] dec_items;

   assign b = req_data.data_byte;
   assign accept = req_valid && req_ready;
   assign tk_acc = {facc_ff[55:0], b};
   assign tk_cnt = fcnt_ff + 5'd1;

   always_comb begin
      step = '0;
      nres = 1'b0;
      phase_in = phase_ff; fcnt_in = fcnt_ff; facc_in = facc_ff;
      aacc_in = aacc_ff; alow_in = alow_ff; rlen_in = rlen_ff; left_in = left_ff;
      sub_in = sub_ff; ptot_in = ptot_ff; items_in = items_ff; skip_in = skip_ff;
      ptype_in = ptype_ff; pfx_in = pfx_ff; plen_in = plen_ff;
      pnum_in = pnum_ff;
      off_in = off_ff + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
      hdr_acc = '0; typ = '0; bleft = '0; open = 1'b0; nbytes = '0;
      dec_items = items_ff - 16'd1;

      if (phase_ff == PH_HDR) begin
         // header bytes: timestamp, type, subtype, length
         if (fcnt_ff == 5'd0) begin
            facc_in = '0; rlen_in = '0; sub_in = '0;
         end
         hdr_acc = facc_in[31:0];
         if (fcnt_ff >= 5'd4 && fcnt_ff < 5'd8) begin
            hdr_acc = {facc_in[23:0], b};
            facc_in = {32'd0, hdr_acc};
         end
         if (fcnt_ff == 5'd7) sub_in = hdr_acc[15:0];
         if (fcnt_ff >= 5'd8) rlen_in = {rlen_in[23:0], b};
         fcnt_in = tk_cnt;
         if (tk_cnt == 5'd12) begin
            typ = facc_in[31:16];
            left_in = rlen_in;
            fcnt_in = '0; facc_in = '0;
            if (typ != TYPE_TD2) begin
               step.res0.error_code = ERR_TYPE; nres = 1'b1;
               phase_in = PH_DRAIN;
            end else if (sub_in == SUB_PEER_TABLE) phase_in = PH_PT_COLL;
            else if (sub_in == SUB_RIB_V4U) phase_in = PH_RIB_SEQ;
            else if (sub_in >= 16'd3 && sub_in <= SUB_LAST_KNOWN) phase_in = PH_SKIP;
            else begin
               step.res0.error_code = ERR_SUBTYPE; nres = 1'b1;
               phase_in = PH_DRAIN;
            end
            bleft = rlen_in;
         end else begin
            bleft = 32'd1;
         end
      end else begin
         bleft = left_ff - 32'd1;
         left_in = bleft;
         case (phase_ff)
            PH_PT_COLL: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= 5'd4) begin phase_in = PH_PT_VNLEN; fcnt_in = '0; facc_in = '0; end
            end
            PH_PT_VNLEN: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= 5'd2) begin
                  skip_in = tk_acc[15:0];
                  phase_in = (tk_acc[15:0] == 16'd0) ? PH_PT_COUNT : PH_PT_VNAME;
                  fcnt_in = '0; facc_in = '0;
               end
            end
            PH_PT_VNAME: begin
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) begin phase_in = PH_PT_COUNT; fcnt_in = '0; facc_in = '0; end
            end
            PH_PT_COUNT: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= 5'd2) begin
                  ptot_in = tk_acc[15:0]; items_in = tk_acc[15:0]; pnum_in = '0;
                  phase_in = (tk_acc[15:0] == 16'd0) ? PH_PT_TRAIL : PH_PT_TYPE;
                  fcnt_in = '0; facc_in = '0;
               end
            end
            PH_PT_TYPE: begin
               ptype_in = b[1:0]; aacc_in = '0;
               phase_in = PH_PT_BGPID; fcnt_in = '0; facc_in = '0;
            end
            PH_PT_BGPID: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= 5'd4) begin
                  pfx_in = tk_acc[31:0];
                  phase_in = PH_PT_ADDR; fcnt_in = '0; facc_in = '0;
               end
            end
            PH_PT_ADDR: begin
               aacc_in = {aacc_ff[55:0], facc_ff[63:56]};
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= (ptype_ff[0] ? 5'd16 : 5'd4)) begin
                  alow_in = tk_acc;
                  phase_in = PH_PT_AS; fcnt_in = '0; facc_in = '0;
               end
            end
            PH_PT_AS: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= (ptype_ff[1] ? 5'd4 : 5'd2)) begin
                  step.res0.kind = ptype_ff[0] ? KIND_PEER_V6 : KIND_PEER_V4;
                  step.res0.peer_slot = pnum_ff;
                  step.res0.peer_as = tk_acc[31:0];
                  step.res0.bgp_id = pfx_ff;
                  step.res0.address_high = aacc_ff;
                  step.res0.address_low = alow_ff;
                  nres = 1'b1;
                  pnum_in = pnum_ff + 16'd1;
                  items_in = dec_items;
                  phase_in = (dec_items == 16'd0) ? PH_PT_TRAIL : PH_PT_TYPE;
                  fcnt_in = '0; facc_in = '0;
               end
            end
            PH_RIB_SEQ: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= 5'd4) begin phase_in = PH_RIB_PLEN; fcnt_in = '0; facc_in = '0; end
            end
            PH_RIB_PLEN: begin
               pfx_in = '0;
               fcnt_in = '0; facc_in = '0;
               if (b > 8'd32) begin
                  plen_in = '0;
                  step.res0.error_code = ERR_LENGTH; nres = 1'b1;
                  phase_in = PH_DRAIN;
               end else begin
                  plen_in = b[5:0];
                  nbytes = (b[5:0] + 6'd7) >> 3;
                  skip_in = {10'd0, nbytes};
                  phase_in = (nbytes == 6'd0) ? PH_RIB_COUNT : PH_RIB_PFX;
               end
            end
            PH_RIB_PFX: begin
               // prefix bytes land left-aligned, at most four
               case (fcnt_ff)
                  5'd0: pfx_in[31:24] = b;
                  5'd1: pfx_in[23:16] = b;
                  5'd2: pfx_in[15:8]  = b;
                  5'd3: pfx_in[7:0]   = b;
                  default: pfx_in = pfx_ff;
               endcase
               fcnt_in = tk_cnt;
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) begin phase_in = PH_RIB_COUNT; fcnt_in = '0; facc_in = '0; end
            end
            PH_RIB_COUNT: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= 5'd2) begin
                  items_in = tk_acc[15:0];
                  fcnt_in = '0; facc_in = '0;
                  if (tk_acc[15:0] != 16'd0) phase_in = PH_RIB_PEER;
                  else if (bleft != 32'd0) begin
                     step.res0.error_code = ERR_LENGTH; nres = 1'b1; phase_in = PH_DRAIN;
                  end else phase_in = PH_RIB_END;
               end
            end
            PH_RIB_PEER: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= 5'd2) begin
                  pnum_in = tk_acc[15:0];
                  phase_in = PH_RIB_TIME; fcnt_in = '0; facc_in = '0;
               end
            end
            PH_RIB_TIME: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= 5'd4) begin phase_in = PH_RIB_ALEN; fcnt_in = '0; facc_in = '0; end
            end
            PH_RIB_ALEN: begin
               facc_in = tk_acc; fcnt_in = tk_cnt;
               if (tk_cnt >= 5'd2) begin
                  skip_in = tk_acc[15:0];
                  fcnt_in = '0; facc_in = '0;
                  if (pnum_ff >= ptot_ff) begin
                     step.res0.error_code = ERR_PEER_IDX; nres = 1'b1; phase_in = PH_DRAIN;
                  end else begin
                     step.res0.kind = KIND_RIB;
                     step.res0.peer_slot = pnum_ff;
                     step.res0.address_low = {32'd0, pfx_ff};
                     step.res0.pfx_len = plen_ff;
                     step.res0.attr_len = tk_acc[15:0];
                     step.res0.attribute_offset = 32'(off_in);
                     nres = 1'b1;
                     if (tk_acc[15:0] == 16'd0) begin
                        items_in = dec_items;
                        if (dec_items != 16'd0) phase_in = PH_RIB_PEER;
                        else if (bleft != 32'd0) begin
                           // second item: leftover bytes in the record
                           step.count1 = 1'b1;
                           step.res1.kind = KIND_DONE;
                           step.res1.record_subtype = sub_ff;
                           step.res1.error_code = ERR_LENGTH;
                           phase_in = PH_DRAIN;
                        end else phase_in = PH_RIB_END;
                     end else phase_in = PH_RIB_ATTR;
                  end
               end
            end
            PH_RIB_ATTR: begin
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) begin
                  items_in = dec_items; fcnt_in = '0; facc_in = '0;
                  if (dec_items != 16'd0) phase_in = PH_RIB_PEER;
                  else if (bleft != 32'd0) begin
                     step.res0.error_code = ERR_LENGTH; nres = 1'b1; phase_in = PH_DRAIN;
                  end else phase_in = PH_RIB_END;
               end
            end
            default: begin
            end
         endcase
      end

      // error-path items are done items carrying the subtype
      if (nres && step.res0.error_code != ERR_OK) begin
         step.res0.kind = KIND_DONE;
         step.res0.record_subtype = sub_in;
      end
      step.count0 = nres;

      // record length used up
      if (bleft == 32'd0) begin
         if (phase_in != PH_DRAIN) begin
            if (nres) begin
               step.count1 = 1'b1;
               step.res1 = '0;
               step.res1.kind = KIND_DONE;
               step.res1.record_subtype = sub_in;
               step.res1.error_code = (phase_in == PH_SKIP || phase_in == PH_PT_TRAIL ||
                                       phase_in == PH_RIB_END) ? ERR_OK : ERR_LENGTH;
            end else begin
               nres = 1'b1;
               step.count0 = 1'b1;
               step.res0.kind = KIND_DONE;
               step.res0.record_subtype = sub_in;
               step.res0.error_code = (phase_in == PH_SKIP || phase_in == PH_PT_TRAIL ||
                                       phase_in == PH_RIB_END) ? ERR_OK : ERR_LENGTH;
            end
         end
         phase_in = PH_HDR; fcnt_in = '0; facc_in = '0;
      end

      // end of stream: close an open record, then back to reset state
      if (req_data.end_of_stream) begin
         open = (phase_in == PH_HDR) ? (fcnt_in != 5'd0) : (phase_in != PH_DRAIN);
         if (open) begin
            if (step.count0) begin
               step.count1 = 1'b1;
               step.res1 = '0;
               step.res1.kind = KIND_DONE;
               step.res1.record_subtype = sub_in;
               step.res1.error_code = ERR_EARLY;
            end else begin
               step.count0 = 1'b1;
               step.res0.kind = KIND_DONE;
               step.res0.record_subtype = sub_in;
               step.res0.error_code = ERR_EARLY;
            end
         end
         phase_in = PH_HDR; fcnt_in = '0; facc_in = '0; aacc_in = '0; alow_in = '0;
         rlen_in = '0; left_in = '0; sub_in = '0; ptot_in = '0; items_in = '0;
         skip_in = '0; ptype_in = '0; pfx_in = '0; plen_in = '0; off_in = '0;
         pnum_in = '0;
      end

      // mark the last item of this byte
      if (step.count1) step.res1.last_of_run = 1'b1;
      else step.res0.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR; fcnt_ff <= '0; facc_ff <= '0; aacc_ff <= '0;
         alow_ff <= '0; rlen_ff <= '0; left_ff <= '0; sub_ff <= '0; ptot_ff <= '0;
         items_ff <= '0; skip_ff <= '0; ptype_ff <= '0; pfx_ff <= '0;
         plen_ff <= '0; off_ff <= '0; pnum_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in; fcnt_ff <= fcnt_in; facc_ff <= facc_in;
         aacc_ff <= aacc_in; alow_ff <= alow_in; rlen_ff <= rlen_in;
         left_ff <= left_in; sub_ff <= sub_in; ptot_ff <= ptot_in;
         items_ff <= items_in; skip_ff <= skip_in; ptype_ff <= ptype_in;
         pfx_ff <= pfx_in; plen_ff <= plen_in; off_ff <= off_in; pnum_ff <= pnum_in;
      end
   end

   assign req_ready = take_ok;

   mrt_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push_step  (step),
      .has_room   (take_ok),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== design/mrt_checker.sv =====
// ----------------------------------------------------------------------------
// mrt_checker
// port-level checks on the table dump parser
// ----------------------------------------------------------------------------
module mrt_checker
   import mrt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a waiting input item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input item changed while waiting");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // error codes only on done items
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_DONE |-> rsp_data.error_code == ERR_OK)
      else $error("error code on a non-done item");

   // rib prefix length stays in range
   a_plen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_RIB |-> rsp_data.pfx_len <= 6'd32)
      else $error("prefix length out of range");

   // no results straight after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind mrt_table_dump_stream_parser mrt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/mrt_table_dump_stream_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_table_dump_stream_parser_test
// drives table dump byte streams (peer tables, rib records, skipped and broken
// records, early ends) into the parser, predicts every result item in a
// cycle-free model of the parser and checks the items in order
// ----------------------------------------------------------------------------
module mrt_table_dump_stream_parser_test;
   import mrt_pkg::*;

   typedef struct {
      req_type data;
      bit      wait_idle;
   } pending_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   pending_type pending_bytes[$];
   pending_type next_pending;
   rsp_type     expected_items[$];
   int          mismatch_count;
   int          burst_left;
   int          gap_left;
   int          hold_left;
   int          ready_cycle;
   int          table_peers;

   // parser shadow state
   logic [4:0]  phase;
   int unsigned field_count;
   logic [63:0] field_acc;
   logic [63:0] addr_acc;
   logic [63:0] addr_low;
   logic [31:0] rec_len;
   logic [31:0] rec_left;
   logic [15:0] cur_sub;
   logic [15:0] known_peers;
   logic [15:0] entries_left;
   logic [15:0] skip_count;
   logic [1:0]  peer_kind_bits;
   logic [31:0] prefix_hold;
   logic [5:0]  prefix_len_hold;
   logic [31:0] byte_offset;
   logic [15:0] peer_number;
   rsp_type     step_items[2];
   int          step_count;

   mrt_table_dump_stream_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_parser();
      phase = PH_HDR;
      field_count = 0;
      field_acc = '0;
      addr_acc = '0;
      addr_low = '0;
      rec_len = '0;
      rec_left = '0;
      cur_sub = '0;
      known_peers = '0;
      entries_left = '0;
      skip_count = '0;
      peer_kind_bits = '0;
      prefix_hold = '0;
      prefix_len_hold = '0;
      byte_offset = '0;
      peer_number = '0;
   endfunction

   function automatic void add_item(logic [1:0] k, logic [15:0] idx, logic [31:0] as_num,
                                    logic [31:0] bgp, logic [63:0] ah, logic [63:0] al,
                                    logic [5:0] pl, logic [15:0] alen, logic [31:0] aoff,
                                    logic [15:0] sb, logic [2:0] err);
      rsp_type r;
      if (step_count >= 2) return;
      r.kind = k;
      r.last_of_run = 1'b0;
      r.peer_slot = idx;
      r.peer_as = as_num;
      r.bgp_id = bgp;
      r.address_high = ah;
      r.address_low = al;
      r.pfx_len = pl;
      r.attr_len = alen;
      r.attribute_offset = aoff;
      r.record_subtype = sb;
      r.error_code = err;
      step_items[step_count] = r;
      step_count++;
   endfunction

   function automatic void add_done(logic [2:0] err);
      add_item(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, 0, cur_sub, err);
   endfunction

   function automatic void enter(logic [4:0] ph);
      phase = ph;
      field_count = 0;
      field_acc = '0;
   endfunction

   function automatic void abort_record(logic [2:0] err);
      add_done(err);
      enter(PH_DRAIN);
   endfunction

   function automatic bit shift_in(logic [7:0] b, int unsigned need);
      field_acc = (field_acc << 8) | 64'(b);
      field_count++;
      return field_count >= need;
   endfunction

   function automatic void close_record();
      case (phase)
         PH_SKIP, PH_PT_TRAIL, PH_RIB_END: add_done(ERR_OK);
         PH_DRAIN: ;
         default: add_done(ERR_LENGTH);
      endcase
      enter(PH_HDR);
   endfunction

   function automatic void entries_done();
      if (rec_left != 0) abort_record(ERR_LENGTH);
      else enter(PH_RIB_END);
   endfunction

   function automatic void next_entry();
      entries_left = entries_left - 16'd1;
      if (entries_left == 0) entries_done();
      else enter(PH_RIB_PEER);
   endfunction

   function automatic void next_peer();
      peer_number = peer_number + 16'd1;
      entries_left = entries_left - 16'd1;
      enter(entries_left == 0 ? PH_PT_TRAIL : PH_PT_TYPE);
   endfunction

   function automatic void header_byte(logic [7:0] b);
      int unsigned c;
      logic [15:0] rtype;
      c = field_count;
      if (c == 0) begin
         field_acc = '0;
         rec_len = '0;
         cur_sub = '0;
      end
      if (c >= 4 && c < 8) field_acc = ((field_acc << 8) | 64'(b)) & 64'hffff_ffff;
      if (c == 7) cur_sub = field_acc[15:0];
      if (c >= 8) rec_len = (rec_len << 8) | 32'(b);
      c++;
      if (c < 12) begin
         field_count = c;
         return;
      end
      rtype = field_acc[31:16];
      rec_left = rec_len;
      if (rtype != TYPE_TD2) abort_record(ERR_TYPE);
      else if (cur_sub == SUB_PEER_TABLE) enter(PH_PT_COLL);
      else if (cur_sub == SUB_RIB_V4U) enter(PH_RIB_SEQ);
      else if (cur_sub > SUB_RIB_V4U && cur_sub <= SUB_LAST_KNOWN) enter(PH_SKIP);
      else abort_record(ERR_SUBTYPE);
      if (rec_left == 0) close_record();
   endfunction

   function automatic void body_byte(logic [7:0] b, logic [31:0] here);
      logic [15:0] n;
      rec_left = rec_left - 32'd1;
      case (phase)
         PH_PT_COLL: if (shift_in(b, 4)) enter(PH_PT_VNLEN);
         PH_PT_VNLEN: begin
            if (shift_in(b, 2)) begin
               skip_count = field_acc[15:0];
               enter(skip_count == 0 ? PH_PT_COUNT : PH_PT_VNAME);
            end
         end
         PH_PT_VNAME: begin
            skip_count = skip_count - 16'd1;
            if (skip_count == 0) enter(PH_PT_COUNT);
         end
         PH_PT_COUNT: begin
            if (shift_in(b, 2)) begin
               known_peers = field_acc[15:0];
               entries_left = known_peers;
               peer_number = '0;
               enter(entries_left == 0 ? PH_PT_TRAIL : PH_PT_TYPE);
            end
         end
         PH_PT_TYPE: begin
            peer_kind_bits = b[1:0];
            addr_acc = '0;
            enter(PH_PT_BGPID);
         end
         PH_PT_BGPID: begin
            if (shift_in(b, 4)) begin
               prefix_hold = field_acc[31:0];
               enter(PH_PT_ADDR);
            end
         end
         PH_PT_ADDR: begin
            // bytes pushed out of the top of the field land in the upper half
            addr_acc = (addr_acc << 8) | (field_acc >> 56);
            if (shift_in(b, peer_kind_bits[0] ? 16 : 4)) begin
               addr_low = field_acc;
               enter(PH_PT_AS);
            end
         end
         PH_PT_AS: begin
            if (shift_in(b, peer_kind_bits[1] ? 4 : 2)) begin
               add_item(peer_kind_bits[0] ? KIND_PEER_V6 : KIND_PEER_V4, peer_number,
                        field_acc[31:0], prefix_hold, addr_acc, addr_low, 0, 0, 0, 0,
                        ERR_OK);
               next_peer();
            end
         end
         PH_RIB_SEQ: if (shift_in(b, 4)) enter(PH_RIB_PLEN);
         PH_RIB_PLEN: begin
            prefix_hold = '0;
            if (b > 8'd32) begin
               prefix_len_hold = '0;
               abort_record(ERR_LENGTH);
            end else begin
               prefix_len_hold = b[5:0];
               n = (16'(b) + 16'd7) / 16'd8;
               skip_count = n;
               enter(n == 0 ? PH_RIB_COUNT : PH_RIB_PFX);
            end
         end
         PH_RIB_PFX: begin
            if (field_count < 4) prefix_hold |= 32'(b) << (24 - 8 * field_count);
            field_count++;
            skip_count = skip_count - 16'd1;
            if (skip_count == 0) enter(PH_RIB_COUNT);
         end
         PH_RIB_COUNT: begin
            if (shift_in(b, 2)) begin
               entries_left = field_acc[15:0];
               if (entries_left == 0) entries_done();
               else enter(PH_RIB_PEER);
            end
         end
         PH_RIB_PEER: begin
            if (shift_in(b, 2)) begin
               peer_number = field_acc[15:0];
               enter(PH_RIB_TIME);
            end
         end
         PH_RIB_TIME: if (shift_in(b, 4)) enter(PH_RIB_ALEN);
         PH_RIB_ALEN: begin
            if (shift_in(b, 2)) begin
               skip_count = field_acc[15:0];
               if (peer_number >= known_peers) begin
                  abort_record(ERR_PEER_IDX);
               end else begin
                  add_item(KIND_RIB, peer_number, 0, 0, 0, 64'(prefix_hold),
                           prefix_len_hold, skip_count, here + 32'd1, 0, ERR_OK);
                  if (skip_count == 0) next_entry();
                  else enter(PH_RIB_ATTR);
               end
            end
         end
         PH_RIB_ATTR: begin
            skip_count = skip_count - 16'd1;
            if (skip_count == 0) next_entry();
         end
         default: ;
      endcase
      if (rec_left == 0) close_record();
   endfunction

   // works out the result items of one accepted byte and queues them
   function automatic void predict_byte(req_type r);
      logic [31:0] here;
      bit open;
      here = byte_offset;
      step_count = 0;
      byte_offset = byte_offset + 32'd1;
      if (phase == PH_HDR) header_byte(r.data_byte);
      else body_byte(r.data_byte, here);
      if (r.end_of_stream) begin
         open = (phase == PH_HDR) ? (field_count != 0) : (phase != PH_DRAIN);
         if (open) add_done(ERR_EARLY);
         clear_parser();
      end
      if (step_count > 0) step_items[step_count - 1].last_of_run = 1'b1;
      for (int i = 0; i < step_count; i++) expected_items.push_back(step_items[i]);
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void queue_byte(logic [7:0] b, bit eos, bit wait_idle);
      pending_type p;
      p.data.data_byte = b;
      p.data.end_of_stream = eos;
      p.wait_idle = wait_idle;
      pending_bytes.push_back(p);
   endfunction

   function automatic void put16(inout logic [7:0] q[$], input logic [15:0] v);
      q.push_back(v[15:8]);
      q.push_back(v[7:0]);
   endfunction

   function automatic void put_rand(inout logic [7:0] q[$], input int n);
      for (int i = 0; i < n; i++) q.push_back(8'($urandom));
   endfunction

   // header plus body; length may be skewed, the stream may end on the last
   // byte or at a random byte inside the record
   function automatic void send_record(logic [15:0] rtype, logic [15:0] rsub,
                                       logic [7:0] body[$], int len_skew,
                                       bit end_last, bit end_inside, bit wait_idle);
      logic [7:0] all[$];
      int len;
      int stop;
      len = body.size() + len_skew;
      if (len < 0) len = 0;
      put_rand(all, 4);
      put16(all, rtype);
      put16(all, rsub);
      put16(all, 16'(len >> 16));
      put16(all, 16'(len));
      for (int i = 0; i < len; i++) all.push_back(i < body.size() ? body[i] : 8'($urandom));
      stop = end_inside ? $urandom_range(0, all.size() - 1) : all.size() - 1;
      for (int i = 0; i <= stop; i++)
         queue_byte(all[i], (i == stop) && (end_last || end_inside), wait_idle && i == 0);
   endfunction

   function automatic void peer_table_body(inout logic [7:0] q[$], input int n);
      logic [7:0] t;
      int vn;
      put_rand(q, 4);
      vn = $urandom_range(0, 3);
      put16(q, 16'(vn));
      put_rand(q, vn);
      put16(q, 16'(n));
      for (int i = 0; i < n; i++) begin
         t = 8'($urandom);
         q.push_back(t);
         put_rand(q, 4);
         put_rand(q, t[0] ? 16 : 4);
         put_rand(q, t[1] ? 4 : 2);
      end
      put_rand(q, $urandom_range(0, 2));
   endfunction

   function automatic void rib_body(inout logic [7:0] q[$], input int plen, input int n,
                                    input int peers);
      int alen;
      put_rand(q, 4);
      q.push_back(8'(plen));
      if (plen <= 32) put_rand(q, (plen + 7) / 8);
      put16(q, 16'(n));
      for (int i = 0; i < n; i++) begin
         if (peers > 0 && $urandom_range(0, 9) != 0) put16(q, 16'($urandom_range(0, peers - 1)));
         else put16(q, 16'($urandom));
         put_rand(q, 4);
         alen = $urandom_range(0, 4);
         put16(q, 16'(alen));
         put_rand(q, alen);
      end
   endfunction

   function automatic int pick_skew();
      return ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 6)) - 3 : 0;
   endfunction

   function automatic void random_record(bit end_last, bit end_inside, bit wait_idle);
      logic [7:0] body[$];
      int sel;
      int n;
      int plen;
      sel = $urandom_range(0, 19);
      if (sel < 4) begin
         n = $urandom_range(0, 4);
         peer_table_body(body, n);
         table_peers = n;
         send_record(TYPE_TD2, SUB_PEER_TABLE, body, pick_skew(), end_last, end_inside,
                     wait_idle);
      end else if (sel < 15) begin
         plen = ($urandom_range(0, 11) == 0) ? $urandom_range(33, 255) : $urandom_range(0, 32);
         rib_body(body, plen, $urandom_range(0, 3), table_peers);
         send_record(TYPE_TD2, SUB_RIB_V4U, body, pick_skew(), end_last, end_inside,
                     wait_idle);
      end else if (sel < 17) begin
         put_rand(body, $urandom_range(0, 5));
         send_record(TYPE_TD2, 16'($urandom_range(3, 6)), body, 0, end_last, end_inside,
                     wait_idle);
      end else if (sel < 18) begin
         put_rand(body, $urandom_range(0, 4));
         send_record(16'($urandom), SUB_RIB_V4U, body, 0, end_last, end_inside, wait_idle);
      end else if (sel < 19) begin
         put_rand(body, $urandom_range(0, 4));
         send_record(TYPE_TD2, ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'd0, body, 0,
                     end_last, end_inside, wait_idle);
      end else begin
         // raw noise bytes
         n = $urandom_range(1, 20);
         for (int i = 0; i < n; i++) queue_byte(8'($urandom), 1'b0, 1'b0);
      end
   endfunction

   function automatic void directed_part();
      logic [7:0] b[$];
      // peer table with v4 and v6 peers, short and long as numbers
      put_rand(b, 4);
      put16(b, 16'd2);
      put_rand(b, 2);
      put16(b, 16'd4);
      for (int i = 0; i < 4; i++) begin
         b.push_back(8'(i) | 8'hfc);
         put_rand(b, 4);
         put_rand(b, i[0] ? 16 : 4);
         put_rand(b, i[1] ? 4 : 2);
      end
      put_rand(b, 2);
      send_record(TYPE_TD2, SUB_PEER_TABLE, b, 0, 0, 0, 0);
      table_peers = 4;
      // rib records: prefix lengths 0, 32, over 32, bad peer index, leftover bytes
      b.delete(); rib_body(b, 0, 1, 4); send_record(TYPE_TD2, SUB_RIB_V4U, b, 0, 0, 0, 0);
      b.delete(); rib_body(b, 32, 2, 4); send_record(TYPE_TD2, SUB_RIB_V4U, b, 0, 0, 0, 0);
      b.delete(); rib_body(b, 255, 1, 4); send_record(TYPE_TD2, SUB_RIB_V4U, b, 0, 0, 0, 0);
      b.delete(); put_rand(b, 4); b.push_back(8'd8); put_rand(b, 1); put16(b, 16'd1);
      put16(b, 16'hffff); put_rand(b, 4); put16(b, 16'd0);
      send_record(TYPE_TD2, SUB_RIB_V4U, b, 0, 0, 0, 0);
      b.delete(); rib_body(b, 24, 1, 4); send_record(TYPE_TD2, SUB_RIB_V4U, b, 3, 0, 0, 0);
      // rib record two bytes too short for its body
      b.delete(); rib_body(b, 16, 1, 4); send_record(TYPE_TD2, SUB_RIB_V4U, b, -2, 0, 0, 0);
      // skipped subtype, empty record, bad type, subtypes zero and seven
      b.delete(); put_rand(b, 3); send_record(TYPE_TD2, 16'd5, b, 0, 0, 0, 0);
      b.delete(); send_record(TYPE_TD2, 16'd3, b, 0, 0, 0, 0);
      b.delete(); put_rand(b, 2); send_record(16'hffff, SUB_PEER_TABLE, b, 0, 0, 0, 0);
      b.delete(); put_rand(b, 1); send_record(TYPE_TD2, 16'd0, b, 0, 0, 0, 0);
      b.delete(); send_record(TYPE_TD2, 16'd7, b, 0, 0, 0, 0);
      // header cut short by end of stream
      for (int i = 0; i < 5; i++) queue_byte(8'($urandom), i == 4, 1'b0);
   endfunction

   // ---------------------------------------------------------------- sender

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) predict_byte(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0 &&
                         (!pending_bytes[0].wait_idle || expected_items.size() == 0)) begin
               next_pending = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_data <= next_pending.data;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         ready_cycle <= 0;
      end else begin
         ready_cycle <= ready_cycle + 1;
         if (ready_cycle == 700) begin
            // long back pressure so the output queue fills and input stalls
            hold_left <= 300;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            case ((ready_cycle / 97) % 3)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) != 0);
               default: rsp_ready <= ($urandom_range(0, 6) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_items.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected item: %p", rsp_data);
         end else begin
            want = expected_items.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.last_of_run !== want.last_of_run ||
                rsp_data.peer_slot !== want.peer_slot || rsp_data.peer_as !== want.peer_as ||
                rsp_data.bgp_id !== want.bgp_id ||
                rsp_data.address_high !== want.address_high ||
                rsp_data.address_low !== want.address_low ||
                rsp_data.pfx_len !== want.pfx_len ||
                rsp_data.attr_len !== want.attr_len ||
                rsp_data.attribute_offset !== want.attribute_offset ||
                rsp_data.record_subtype !== want.record_subtype ||
                rsp_data.error_code !== want.error_code) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("item mismatch\n  expected %p\n  actual   %p", want, rsp_data);
            end
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      mismatch_count = 0;
      table_peers = 0;
      clear_parser();
      reset = 1'b1;
      directed_part();
      while (pending_bytes.size() < 1050) begin
         bit end_last;
         bit end_inside;
         end_inside = ($urandom_range(0, 24) == 0);
         end_last = ($urandom_range(0, 7) == 0);
         random_record(end_last, end_inside, $urandom_range(0, 39) == 0);
         if (end_last || end_inside) table_peers = 0;
      end
      queue_byte(8'($urandom), 1'b1, 1'b1);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_bytes.size() == 0 && !req_valid);
      wait (expected_items.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_items.size() == 0) begin
         $display("mrt_table_dump_stream_parser_test passed");
      end else begin
         $display("mrt_table_dump_stream_parser_test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("mrt_table_dump_stream_parser_test failed");
      $finish;
   end

endmodule

// ===== mrt_table_dump_stream_parser.f =====
design/mrt_pkg.sv
design/mrt_out_queue.sv
design/mrt_table_dump_stream_parser.sv
design/mrt_checker.sv
sim/mrt_table_dump_stream_parser_test.sv
